// File: hw/rtl/q24_8_fixed_point_alu_unit_macros.svh
// ----------------------------------------------------------------------------
// q24_8_fixed_point_alu_unit_macros
// Assertion macros shared by the checker.
// ----------------------------------------------------------------------------
`ifndef Q24_8_FIXED_POINT_ALU_UNIT_MACROS_SVH
`define Q24_8_FIXED_POINT_ALU_UNIT_MACROS_SVH

// assert that a implies b on the same edge
`define Q8A_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");

// assert that a implies b on the next edge
`define Q8A_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");

`endif

// File: hw/rtl/q8alu_pkg.sv
// ----------------------------------------------------------------------------
// q8alu_pkg
// Opcodes, widths and decoded-operation types of the fixed-point unit.
// ----------------------------------------------------------------------------
package q8alu_pkg;

  localparam int FracBitsDef = 8;
  localparam int WordBitsDef = 32;
  localparam int FieldBits   = 32;
  localparam int ModeBits    = 4;
  localparam int QueueDepth  = 4;

  typedef enum logic [ModeBits-1:0] {
    OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
    OP_GT = 4'd4, OP_LT = 4'd5, OP_GE = 4'd6, OP_LE = 4'd7,
    OP_EQ = 4'd8, OP_NE = 4'd9, OP_MIN = 4'd10, OP_MAX = 4'd11,
    OP_INC = 4'd12, OP_DEC = 4'd13, OP_FROM_INT = 4'd14, OP_TO_INT = 4'd15
  } op_t;

  typedef struct packed {
    op_t  op;
    logic b_zero;
    logic is_div;
  } cls_t;

endpackage

// File: hw/rtl/q8alu_if.sv
// ----------------------------------------------------------------------------
// q8alu_if
// Valid/ready channel carrying a generic payload.
// ----------------------------------------------------------------------------
interface q8alu_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/q24_8_fixed_point_alu_unit.sv
// ----------------------------------------------------------------------------
// q24_8_fixed_point_alu_unit
// Signed Q24.8 arithmetic unit with valid/ready channels.
// ----------------------------------------------------------------------------
// One operation per cycle enters while the queue is not full; every operation
// passes in order through the execution pipeline, whose length is set by the
// divider's one-bit-per-stage steps. A four-entry queue with a registered head
// separates the input side from the execution pipeline.
module q24_8_fixed_point_alu_unit import q8alu_pkg::*; #(
  parameter int FracBits = FracBitsDef,
  parameter int WordBits = WordBitsDef
) (
  input logic clk,
  input logic rst,
  q8alu_if.sink   in_ch,
  q8alu_if.source out_ch
);
  cls_t                       q_cls;
  logic                       q_valid, q_ready;
  logic signed [WordBits-1:0] q_a, q_b;
  logic signed [FieldBits-1:0] res;
  logic                       cmp, dz;

  q8alu_front #(.WordBits(WordBits)) u_front (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_mode(in_ch.data.mode), .in_a(in_ch.data.a_raw), .in_b(in_ch.data.b_raw),
    .q_valid, .q_ready, .q_cls, .q_a, .q_b
  );

  q8alu_back #(.FracBits(FracBits), .WordBits(WordBits)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_cls, .q_a, .q_b,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_result(res), .out_cmp(cmp), .out_dz(dz)
  );

  assign out_ch.data.result_raw   = res;
  assign out_ch.data.compare_true = cmp;
  assign out_ch.data.div_by_zero  = dz;
endmodule

// File: hw/rtl/q8alu_front.sv
// ----------------------------------------------------------------------------
// q8alu_front
// Accepts operations, sign-extends operands, classifies, and queues them.
// ----------------------------------------------------------------------------
module q8alu_front import q8alu_pkg::*; #(
  parameter int WordBits = WordBitsDef
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [ModeBits-1:0]        in_mode,
  input  logic signed [FieldBits-1:0] in_a,
  input  logic signed [FieldBits-1:0] in_b,
  output logic                       q_valid,
  input  logic                       q_ready,
  output cls_t                       q_cls,
  output logic signed [WordBits-1:0] q_a,
  output logic signed [WordBits-1:0] q_b
);
  localparam int OpW  = (WordBits < FieldBits) ? WordBits : FieldBits;
  localparam int PtrW = $clog2(QueueDepth);

  cls_t                       cls_mem [QueueDepth];
  logic signed [WordBits-1:0] a_mem   [QueueDepth];
  logic signed [WordBits-1:0] b_mem   [QueueDepth];
  logic [PtrW-1:0]            wr_ptr;
  logic [PtrW-1:0]            rd_ptr;
  logic [PtrW:0]              count;
  logic signed [WordBits-1:0] a_ext;
  logic signed [WordBits-1:0] b_ext;
  cls_t                       cls_in;
  logic                       push;
  logic                       pop;
  logic                       load_head;
  logic                       mem_empty;
  logic                       bypass;
  logic                       mem_push;
  logic                       mem_pop;
  logic                       head_vld;
  cls_t                       head_cls;
  logic signed [WordBits-1:0] head_a;
  logic signed [WordBits-1:0] head_b;

  assign a_ext = WordBits'($signed(in_a[OpW-1:0]));
  assign b_ext = WordBits'($signed(in_b[OpW-1:0]));

  always_comb begin
    cls_in.op     = op_t'(in_mode);
    cls_in.is_div = (op_t'(in_mode) == OP_DIV);
    cls_in.b_zero = (b_ext == '0);
  end

  assign in_ready  = (count != (PtrW+1)'(QueueDepth));
  assign push      = in_valid && in_ready;
  assign q_valid   = head_vld;
  assign pop       = head_vld && q_ready;
  assign load_head = !head_vld || pop;
  assign mem_empty = (count == '0);
  assign bypass    = push && load_head && mem_empty;
  assign mem_push  = push && !bypass;
  assign mem_pop   = load_head && !mem_empty;
  assign q_cls     = head_cls;
  assign q_a       = head_a;
  assign q_b       = head_b;

  always_ff @(posedge clk) begin
    if (mem_push) begin
      cls_mem[wr_ptr] <= cls_in;
      a_mem[wr_ptr]   <= a_ext;
      b_mem[wr_ptr]   <= b_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (load_head) begin
      if (!mem_empty) begin
        head_cls <= cls_mem[rd_ptr];
        head_a   <= a_mem[rd_ptr];
        head_b   <= b_mem[rd_ptr];
      end else begin
        head_cls <= cls_in;
        head_a   <= a_ext;
        head_b   <= b_ext;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      count    <= '0;
      head_vld <= 1'b0;
    end else begin
      if (mem_push) wr_ptr <= wr_ptr + 1'b1;
      if (mem_pop) rd_ptr <= rd_ptr + 1'b1;
      if (load_head) head_vld <= !mem_empty || push;
      count <= count + (PtrW+1)'(mem_push) - (PtrW+1)'(mem_pop);
    end
  end
endmodule

// File: hw/rtl/q8alu_back.sv
// ----------------------------------------------------------------------------
// q8alu_back
// Execution pipeline: multiply in partial products, radix-2 divide one quotient
// bit per stage, simple ops carried alongside; elastic on stall.
// ----------------------------------------------------------------------------
module q8alu_back import q8alu_pkg::*; #(
  parameter int FracBits = FracBitsDef,
  parameter int WordBits = WordBitsDef
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  output logic                        q_ready,
  input  cls_t                        q_cls,
  input  logic signed [WordBits-1:0]  q_a,
  input  logic signed [WordBits-1:0]  q_b,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [FieldBits-1:0] out_result,
  output logic                        out_cmp,
  output logic                        out_dz
);
  localparam int W    = WordBits;
  localparam int DivN = W + FracBits;       // dividend bits
  localparam int HW   = (W + 1) / 2;        // multiplier half width
  localparam int NSt  = DivN + 3;           // total stages
  localparam int PW   = 2 * W;

  typedef struct packed {
    logic           neg;
    logic [W-1:0]   simple;
    logic           cmp;
    logic           dz;
    logic           is_mul;
    logic           is_div;
    logic [W-1:0]   ua;
    logic [W-1:0]   ub;
    logic [PW-1:0]  prod;
    logic [DivN-1:0] num;
    logic [W:0]     rem;
  } st_t;

  st_t           st      [NSt];
  st_t           st_next [NSt];
  logic [NSt-1:0] vld;
  logic [NSt-1:0] adv;
  st_t           s0;

  logic [W-1:0] ua_c, ub_c;
  logic         lt_ab, lt_ba;

  always_comb begin
    ua_c  = q_a[W-1] ? W'(-q_a) : W'(q_a);
    ub_c  = q_b[W-1] ? W'(-q_b) : W'(q_b);
    lt_ab = q_a < q_b;
    lt_ba = q_b < q_a;
    s0        = '0;
    s0.ua     = ua_c;
    s0.ub     = ub_c;
    s0.neg    = q_a[W-1] ^ q_b[W-1];
    s0.is_mul = (q_cls.op == OP_MUL);
    s0.is_div = q_cls.is_div && !q_cls.b_zero;
    s0.dz     = q_cls.is_div && q_cls.b_zero;
    s0.num    = {ua_c, FracBits'(0)};
    unique case (q_cls.op)
      OP_ADD:      s0.simple = W'(q_a + q_b);
      OP_SUB:      s0.simple = W'(q_a - q_b);
      OP_GT:       s0.cmp = lt_ba;
      OP_LT:       s0.cmp = lt_ab;
      OP_GE:       s0.cmp = !lt_ab;
      OP_LE:       s0.cmp = !lt_ba;
      OP_EQ:       s0.cmp = (q_a == q_b);
      OP_NE:       s0.cmp = (q_a != q_b);
      OP_MIN:      s0.simple = lt_ba ? q_b : q_a;
      OP_MAX:      s0.simple = lt_ab ? q_b : q_a;
      OP_INC:      s0.simple = W'(q_a + 1'b1);
      OP_DEC:      s0.simple = W'(q_a - 1'b1);
      OP_FROM_INT: s0.simple = W'(q_a <<< FracBits);
      OP_TO_INT:   s0.simple = W'(q_a >>> FracBits);
      default:     s0.simple = '0;
    endcase
  end

  // a stage advances when its successor is free or moving
  always_comb begin
    adv[NSt-1] = !vld[NSt-1] || out_ready;
    for (int i = NSt - 2; i >= 0; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end
  assign q_ready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= q_valid;
      for (int i = 1; i < NSt; i++) begin
        if (adv[i]) vld[i] <= vld[i-1];
      end
    end
  end

  // stage 0: operands; stage 1: product; stages 2..NSt-2: one divide step
  // each; last: hold for sign and select
  always_comb begin
    logic [W:0] trial;
    st_next[0] = s0;
    st_next[1] = st[0];
    st_next[1].prod = PW'({HW'(0), st[0].ua[HW-1:0]} * st[0].ub)
                    + (PW'({st[0].ua >> HW} * st[0].ub) << HW);
    for (int i = 2; i < NSt - 1; i++) begin
      st_next[i] = st[i-1];
      trial = {st[i-1].rem[W-1:0], st[i-1].num[DivN-1]};
      if (trial >= {1'b0, st[i-1].ub}) begin
        st_next[i].rem = trial - {1'b0, st[i-1].ub};
        st_next[i].num = {st[i-1].num[DivN-2:0], 1'b1};
      end else begin
        st_next[i].rem = trial;
        st_next[i].num = {st[i-1].num[DivN-2:0], 1'b0};
      end
    end
    st_next[NSt-1] = st[NSt-2];
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NSt; i++) begin
      if (adv[i]) st[i] <= st_next[i];
    end
  end

  logic [W-1:0] mq, dq, res_w;
  always_comb begin
    mq = W'(st[NSt-1].prod >> FracBits);
    dq = W'(st[NSt-1].num);
    if (st[NSt-1].neg) begin
      mq = W'(-mq);
      dq = W'(-dq);
    end
    priority if (st[NSt-1].is_mul) res_w = mq;
    else if (st[NSt-1].is_div) res_w = dq;
    else res_w = st[NSt-1].simple;
  end

  assign out_valid  = vld[NSt-1];
  assign out_result = FieldBits'($signed(res_w));
  assign out_cmp    = st[NSt-1].cmp;
  assign out_dz     = st[NSt-1].dz;
endmodule

// File: hw/rtl/q8alu_checker.sv
// ----------------------------------------------------------------------------
// q8alu_checker
// Port-level checks of the fixed-point unit's result channel.
// ----------------------------------------------------------------------------
`include "q24_8_fixed_point_alu_unit_macros.svh"

module q8alu_checker (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input logic [31:0] result_raw,
  input logic compare_true,
  input logic div_by_zero
);
  `Q8A_IMPLY(a_dz_zero, clk, rst, out_valid && div_by_zero, result_raw == 32'd0)
  `Q8A_IMPLY(a_cmp_zero, clk, rst, out_valid && compare_true, result_raw == 32'd0)
  `Q8A_IMPLY(a_excl, clk, rst, out_valid, !(compare_true && div_by_zero))
  `Q8A_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid)
endmodule

bind q24_8_fixed_point_alu_unit q8alu_checker u_chk (
  .clk(clk), .rst(rst),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .result_raw(out_ch.data.result_raw),
  .compare_true(out_ch.data.compare_true),
  .div_by_zero(out_ch.data.div_by_zero)
);

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives random and corner-case operations into the Q24.8 fixed-point unit
// with and without random source and sink stalls, predicts each result and compares
// every output field against the prediction in arrival order.
// ----------------------------------------------------------------------------
module testbench;
  import q8alu_pkg::*;

  typedef struct packed {
    op_t         mode;
    logic [31:0] a_raw;
    logic [31:0] b_raw;
  } alu_req_t;

  typedef struct packed {
    logic [31:0] result_raw;
    logic        compare_true;
    logic        div_by_zero;
  } alu_rsp_t;

  class alu_result_board;
    alu_rsp_t pending_results[$];
    int       mismatches = 0;

    function alu_rsp_t predict_alu(alu_req_t req);
      alu_rsp_t   r;
      logic signed [31:0] a;
      logic signed [31:0] b;
      longint     wide;
      a = req.a_raw;
      b = req.b_raw;
      r = '0;
      case (req.mode)
        OP_ADD: r.result_raw = a + b;
        OP_SUB: r.result_raw = a - b;
        OP_MUL: begin
          wide = (longint'(a) * longint'(b)) / 256;
          r.result_raw = wide[31:0];
        end
        OP_DIV: begin
          if (b == 0) begin
            r.div_by_zero = 1'b1;
          end else begin
            wide = (longint'(a) * 256) / longint'(b);
            r.result_raw = wide[31:0];
          end
        end
        OP_GT: r.compare_true = a > b;
        OP_LT: r.compare_true = a < b;
        OP_GE: r.compare_true = a >= b;
        OP_LE: r.compare_true = a <= b;
        OP_EQ: r.compare_true = a == b;
        OP_NE: r.compare_true = a != b;
        OP_MIN: r.result_raw = (b < a) ? b : a;
        OP_MAX: r.result_raw = (a < b) ? b : a;
        OP_INC: r.result_raw = a + 1;
        OP_DEC: r.result_raw = a - 1;
        OP_FROM_INT: r.result_raw = a <<< 8;
        default: r.result_raw = a >>> 8;
      endcase
      return r;
    endfunction

    function void note_operands(alu_req_t req);
      pending_results.push_back(predict_alu(req));
    endfunction

    function void check_result(alu_rsp_t got);
      alu_rsp_t exp_rsp;
      if (pending_results.size() == 0) begin
        $error("unexpected result %h", got);
        mismatches++;
        return;
      end
      exp_rsp = pending_results.pop_front();
      if (got.result_raw !== exp_rsp.result_raw) begin
        $error("result_raw expected %h actual %h", exp_rsp.result_raw, got.result_raw);
        mismatches++;
      end
      if (got.compare_true !== exp_rsp.compare_true) begin
        $error("compare_true expected %b actual %b", exp_rsp.compare_true,
               got.compare_true);
        mismatches++;
      end
      if (got.div_by_zero !== exp_rsp.div_by_zero) begin
        $error("div_by_zero expected %b actual %b", exp_rsp.div_by_zero,
               got.div_by_zero);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  q8alu_if #(.payload_t(alu_req_t)) in_ch ();
  q8alu_if #(.payload_t(alu_rsp_t)) out_ch ();

  q24_8_fixed_point_alu_unit DUT (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  alu_result_board board = new();
  int  send_idle = 38;
  int  recv_idle = 54;
  bit  hold_req = 1'b0;
  int  quiet_cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  // sink side: random stalls, plus one long hold-off on request
  initial begin
    @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready = 1'b0;
        repeat (300) @(negedge clk);
        hold_req = 1'b0;
      end
      out_ch.ready = ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) board.check_result(out_ch.data);
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= 3000) begin
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  task automatic send_op(op_t mode, logic [31:0] a, logic [31:0] b);
    alu_req_t req;
    req.mode = mode;
    req.a_raw = a;
    req.b_raw = b;
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.data = req;
    do @(posedge clk); while (!in_ch.ready);
    board.note_operands(req);
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(5))
      0: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
      1: return $urandom_range(2) - 1;
      2: return $urandom_range(4095) - 2048;
      3: return ($urandom_range(511) - 256) <<< 8;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random(int count);
    op_t         mode;
    logic [31:0] b;
    repeat (count) begin
      mode = op_t'($urandom_range(15));
      b = pick_operand();
      if (mode == OP_DIV && $urandom_range(7) == 0) b = '0;
      if (mode inside {[OP_GT:OP_NE]} && $urandom_range(3) == 0) begin
        send_op(mode, b, b);
      end else begin
        send_op(mode, pick_operand(), b);
      end
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (board.pending_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_op(OP_ADD, 32'h7fff_ffff, 32'h0000_0001);
    send_op(OP_SUB, 32'h8000_0000, 32'h0000_0001);
    send_op(OP_MUL, 32'h8000_0000, 32'h8000_0000);
    send_op(OP_MUL, 32'hffff_ff01, 32'h0000_0001);
    send_op(OP_MUL, 32'h7fff_ffff, 32'h7fff_ffff);
    send_op(OP_DIV, 32'h0000_0100, 32'h0000_0000);
    send_op(OP_DIV, 32'h8000_0000, 32'hffff_ffff);
    send_op(OP_DIV, 32'h8000_0000, 32'hffff_ff00);
    send_op(OP_DIV, 32'hffff_fd00, 32'h0000_0200);
    send_op(OP_GT, 32'h8000_0000, 32'h7fff_ffff);
    send_op(OP_LT, 32'h8000_0000, 32'h7fff_ffff);
    send_op(OP_GE, 32'h1234_5678, 32'h1234_5678);
    send_op(OP_LE, 32'h7fff_ffff, 32'h8000_0000);
    send_op(OP_EQ, 32'hdead_beef, 32'hdead_beef);
    send_op(OP_NE, 32'h0000_0000, 32'hffff_ffff);
    send_op(OP_MIN, 32'h8000_0000, 32'h7fff_ffff);
    send_op(OP_MAX, 32'h8000_0000, 32'h7fff_ffff);
    send_op(OP_INC, 32'h7fff_ffff, 32'hffff_ffff);
    send_op(OP_DEC, 32'h8000_0000, 32'h1234_5678);
    send_op(OP_FROM_INT, 32'h0080_0000, 32'h0);
    send_op(OP_FROM_INT, 32'hffff_ffff, 32'h0);
    send_op(OP_TO_INT, 32'hffff_ff01, 32'h0);
    send_op(OP_TO_INT, 32'h7fff_ffff, 32'h0);
    send_op(OP_TO_INT, 32'h8000_0000, 32'h0);

    hold_req = 1'b1;
    send_random(450);
    drain_results();

    send_idle = 54;
    recv_idle = 38;
    send_random(450);
    drain_results();

    send_idle = 0;
    recv_idle = 0;
    send_random(450);
    drain_results();

    repeat (60) @(posedge clk);
    if (board.mismatches == 0 && board.pending_results.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end
endmodule

// File: q24_8_fixed_point_alu_unit.f
+incdir+hw/rtl
hw/rtl/q8alu_pkg.sv
hw/rtl/q8alu_if.sv
hw/rtl/q8alu_front.sv
hw/rtl/q8alu_back.sv
hw/rtl/q24_8_fixed_point_alu_unit.sv
hw/rtl/q8alu_checker.sv
tb/testbench.sv
